>>> rtl/bbc_pkg.sv
// ---------------------------------------------------------------------------
// bbc_pkg: shared types for the block buffer cache LRU core
// Beat structs, request and status codes, sequencer states.
// ---------------------------------------------------------------------------
package bbc_pkg;

   localparam int unsigned DefaultEntries = 32;

   typedef enum logic [2:0] {
      REQ_GET      = 3'd0,
      REQ_RELEASE  = 3'd1,
      REQ_DIRTY    = 3'd2,
      REQ_RD_DONE  = 3'd3,
      REQ_RD_FAIL  = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_HIT   = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_DONE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  device_id;
      logic [31:0] block_number;
      logic [4:0]  block_size_log2;
      logic [4:0]  target_slot;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  granted_slot;
      logic        is_uptodate;
      logic        writeback_valid;
      logic [3:0]  writeback_device;
      logic [31:0] writeback_block;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,   // scan tags, one slot a cycle
      S_VICTIM,   // scan recency list, oldest first
      S_VCHECK,   // registered victim read
      S_FIND,     // locate slot in recency list
      S_SHIFT,    // shift recency list, one position a cycle
      S_TGT,      // registered target read for non-get requests
      S_RESP
   } state_type;

endpackage

>>> rtl/block_buffer_cache_lru_core.sv
// ---------------------------------------------------------------------------
// block_buffer_cache_lru_core: buffer cache tag and LRU engine
// Sequencer over slot tables held in memories; one slot examined per cycle.
// ---------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_beat      beat taken when start && !busy
//  response  rsp_strobe, rsp_beat       one cycle per beat, no stall
//
//  Steps, from the accepting edge to the end of the response beat: non-get
//  beats take the target read, the response build and the beat. A get scans up to
//  ENTRIES tags; a hit then walks the recency list (FIND/SHIFT); a miss
//  takes the victim scan, the victim check and the shift instead; with no
//  free slot the get ends after the victim scan.
//  Reset: valid, refs, dirty and uptodate are flip-flop arrays cleared at
//  once; recency list gets a fill count so no clearing pass is needed.
//  The receiver cannot stall; busy stays high through the response beat.
// ---------------------------------------------------------------------------
module block_buffer_cache_lru_core
   import bbc_pkg::*;
#(
   parameter int unsigned ENTRIES = DefaultEntries
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_beat,
   output logic         rsp_strobe,
   output rsp_type      rsp_beat
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   // tag memories (no reset needed: guarded by valid)
   logic [31:0] tag_block_mem [ENTRIES];
   logic [3:0]  tag_dev_mem   [ENTRIES];
   logic [4:0]  tag_size_mem  [ENTRIES];
   // recency list memory; position p at or above fill count reads LAST-p after reset
   logic [IW-1:0] rec_mem [ENTRIES];
   logic [CW-1:0] rec_fill_ff, rec_fill_in;

   logic [ENTRIES-1:0] valid_ff, valid_in, dirty_ff, dirty_in, upd_ff, upd_in;
   logic [15:0] refs_ff [ENTRIES];
   logic [15:0] refs_in [ENTRIES];

   state_type     state_ff, state_in;
   req_type_type  req_ff, req_in;
   logic [IW-1:0] idx_ff, idx_in;       // scan index
   logic [IW-1:0] slot_ff, slot_in;     // chosen slot
   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;

   // memory ports
   logic [31:0] rd_block_ff;
   logic [3:0]  rd_dev_ff;
   logic [4:0]  rd_size_ff;
   logic [IW-1:0] rd_rec_ff, rd_rec_raw;
   logic [IW-1:0] tag_addr, rec_raddr, rec_waddr, rec_wdata;
   logic          tag_we, rec_we;
   logic [IW-1:0] rec_rpos_ff;
   logic          rec_rfill_ff;

   always_ff @(posedge clock) begin
      rd_block_ff <= tag_block_mem[tag_addr];
      rd_dev_ff   <= tag_dev_mem[tag_addr];
      rd_size_ff  <= tag_size_mem[tag_addr];
      if (tag_we) begin
         tag_block_mem[tag_addr] <= req_ff.block_number;
         tag_dev_mem[tag_addr]   <= req_ff.device_id;
         tag_size_mem[tag_addr]  <= req_ff.block_size_log2;
      end
      rd_rec_raw   <= rec_mem[rec_raddr];
      rec_rpos_ff  <= rec_raddr;
      rec_rfill_ff <= (CW'(rec_raddr) < rec_fill_ff);
      if (rec_we)
         rec_mem[rec_waddr] <= rec_wdata;
   end
   assign rd_rec_ff = rec_rfill_ff ? rd_rec_raw : (LAST - rec_rpos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         strobe_ff   <= 1'b0;
         valid_ff    <= '0;
         dirty_ff    <= '0;
         upd_ff      <= '0;
         rec_fill_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) refs_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         strobe_ff   <= strobe_in;
         valid_ff    <= valid_in;
         dirty_ff    <= dirty_in;
         upd_ff      <= upd_in;
         rec_fill_ff <= rec_fill_in;
         for (int i = 0; i < ENTRIES; i++) refs_ff[i] <= refs_in[i];
      end
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   logic tag_match, tgt_ok;
   assign tag_match = valid_ff[idx_ff] && rd_block_ff == req_ff.block_number
                      && rd_dev_ff == req_ff.device_id
                      && rd_size_ff == req_ff.block_size_log2;
   assign tgt_ok = 32'(req_ff.target_slot) < 32'(ENTRIES);

   always_comb begin
      logic [IW-1:0] ts;
      ts          = IW'(req_ff.target_slot);
      state_in    = state_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      slot_in     = slot_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      valid_in    = valid_ff;
      dirty_in    = dirty_ff;
      upd_in      = upd_ff;
      refs_in     = refs_ff;
      rec_fill_in = rec_fill_ff;
      tag_addr    = idx_ff;
      tag_we      = 1'b0;
      rec_raddr   = idx_ff;
      rec_we      = 1'b0;
      rec_waddr   = idx_ff;
      rec_wdata   = rd_rec_ff;
      unique case (state_ff)
         S_IDLE: begin
            tag_addr = '0;
            rec_raddr = '0;
            if (start && !busy) begin
               req_in = req_beat;
               idx_in = '0;
               rsp_in = '0;
               rsp_in.status = ST_DONE;
               if (req_beat.req_type == REQ_GET) begin
                  state_in = S_LOOKUP;
                  tag_addr = '0;
               end else begin
                  state_in = S_TGT;
               end
            end
         end
         S_LOOKUP: begin
            // tag data for idx_ff is registered now
            if (tag_match) begin
               slot_in = idx_ff;
               if (refs_ff[idx_ff] != 16'hFFFF)
                  refs_in[idx_ff] = refs_ff[idx_ff] + 16'd1;
               rsp_in.status       = ST_HIT;
               rsp_in.granted_slot = 5'(idx_ff);
               rsp_in.is_uptodate  = upd_ff[idx_ff];
               idx_in    = '0;
               rec_raddr = '0;
               state_in  = S_FIND;
            end else if (idx_ff == LAST) begin
               idx_in    = '0;
               rec_raddr = '0;
               state_in  = S_VICTIM;
            end else begin
               idx_in   = idx_ff + 1'b1;
               tag_addr = idx_ff + 1'b1;
            end
         end
         S_VICTIM: begin
            // rd_rec_ff is the slot at position idx_ff
            if (refs_ff[rd_rec_ff] == 16'd0) begin
               slot_in  = rd_rec_ff;
               tag_addr = rd_rec_ff;
               state_in = S_VCHECK;
            end else if (idx_ff == LAST) begin
               rsp_in.status = ST_FULL;
               state_in      = S_RESP;
            end else begin
               idx_in    = idx_ff + 1'b1;
               rec_raddr = idx_ff + 1'b1;
            end
         end
         S_VCHECK: begin
            // old tag of the victim is registered
            tag_addr = slot_ff;
            if (valid_ff[slot_ff] && dirty_ff[slot_ff]) begin
               rsp_in.writeback_valid  = 1'b1;
               rsp_in.writeback_device = rd_dev_ff;
               rsp_in.writeback_block  = rd_block_ff;
            end
            tag_we = 1'b1;
            dirty_in[slot_ff] = 1'b0;
            valid_in[slot_ff] = 1'b1;
            upd_in[slot_ff]   = 1'b0;
            refs_in[slot_ff]  = 16'd1;
            rsp_in.status       = ST_MISS;
            rsp_in.granted_slot = 5'(slot_ff);
            rsp_in.is_uptodate  = 1'b0;
            // victim position is idx_ff: shift from there
            rec_raddr = (idx_ff == LAST) ? idx_ff : idx_ff + 1'b1;
            state_in  = S_SHIFT;
         end
         S_FIND: begin
            if (rd_rec_ff == slot_ff) begin
               rec_raddr = (idx_ff == LAST) ? idx_ff : idx_ff + 1'b1;
               state_in  = S_SHIFT;
            end else begin
               idx_in    = idx_ff + 1'b1;
               rec_raddr = idx_ff + 1'b1;
            end
         end
         S_SHIFT: begin
            // position idx_ff takes the entry at idx_ff+1 (registered)
            rec_we = 1'b1;
            rec_waddr = idx_ff;
            if (idx_ff == LAST) begin
               rec_wdata   = slot_ff;
               rec_fill_in = CW'(ENTRIES);
               state_in    = S_RESP;
            end else begin
               rec_wdata = rd_rec_ff;
               if (CW'(idx_ff) >= rec_fill_ff) rec_fill_in = CW'(idx_ff) + 1'b1;
               idx_in    = idx_ff + 1'b1;
               rec_raddr = (idx_ff + 1'b1 == LAST) ? LAST : idx_ff + 2'd2;
            end
         end
         S_TGT: begin
            tag_addr = ts;
            state_in = S_RESP;
            if (!tgt_ok) begin
               // out of range: answer done only
            end else if (req_ff.req_type == REQ_RELEASE) begin
               // tag read issued here lands next cycle
               state_in = S_VCHECK;
               if (valid_ff[ts] && dirty_ff[ts]) begin
                  rsp_in.writeback_valid = 1'b1;
                  dirty_in[ts] = 1'b0;
               end
               if (refs_ff[ts] != 16'd0) refs_in[ts] = refs_ff[ts] - 16'd1;
               state_in = S_RESP;
               slot_in  = ts;
            end else if (req_ff.req_type == REQ_DIRTY) begin
               if (valid_ff[ts]) dirty_in[ts] = 1'b1;
            end else if (req_ff.req_type == REQ_RD_DONE) begin
               if (valid_ff[ts]) upd_in[ts] = 1'b1;
            end else if (req_ff.req_type == REQ_RD_FAIL) begin
               valid_in[ts] = 1'b0;
               dirty_in[ts] = 1'b0;
               upd_in[ts]   = 1'b0;
               refs_in[ts]  = '0;
            end
         end
         S_RESP: begin
            if (rsp_ff.writeback_valid && rsp_ff.status == ST_DONE) begin
               rsp_in.writeback_device = rd_dev_ff;
               rsp_in.writeback_block  = rd_block_ff;
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy       = (state_ff != S_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_beat   = rsp_ff;

   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe while idle");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double response beat");
   a_start_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("beat taken but not busy");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rec_fill_ff <= CW'(ENTRIES)) else $error("recency fill overrun");

endmodule

>>> bench/block_buffer_cache_lru_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_buffer_cache_lru_core_test: self-checking bench for the LRU core
// Drives request beats, keeps its own slot tables and recency list, and
// compares every response beat field by field with the predicted one.
// ---------------------------------------------------------------------------
module block_buffer_cache_lru_core_test;
   import bbc_pkg::*;

   localparam int Slots = 32;
   localparam int CycleLimit = 1000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_type_type req_beat = '0;
   logic         rsp_strobe;
   rsp_type      rsp_beat;

   block_buffer_cache_lru_core #(.ENTRIES(Slots)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_beat(req_beat), .rsp_strobe(rsp_strobe), .rsp_beat(rsp_beat)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // predicted cache state
   logic        slot_valid [Slots];
   logic [31:0] slot_block [Slots];
   logic [3:0]  slot_dev [Slots];
   logic [4:0]  slot_size [Slots];
   logic [15:0] slot_refs [Slots];
   logic        slot_dirty [Slots];
   logic        slot_fresh [Slots];
   int          lru_list [Slots];   // index 0 = oldest

   rsp_type pending_rsp [$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      idle_pct = 0;

   // Move a slot to the newest end of the recency list.
   task automatic touch_slot(input int s);
      int p;
      p = 0;
      while (p < Slots && lru_list[p] != s) p++;
      for (; p + 1 < Slots; p++) lru_list[p] = lru_list[p + 1];
      lru_list[Slots - 1] = s;
   endtask

   task automatic predict_cache(input req_type_type r, output rsp_type o);
      int hit;
      int s;
      o = '0;
      if (r.req_type == REQ_GET) begin
         hit = -1;
         for (int i = 0; i < Slots; i++)
            if (hit < 0 && slot_valid[i] && slot_block[i] == r.block_number &&
                slot_dev[i] == r.device_id && slot_size[i] == r.block_size_log2)
               hit = i;
         if (hit >= 0) begin
            if (slot_refs[hit] != 16'hFFFF) slot_refs[hit]++;
            o.status = ST_HIT;
            o.granted_slot = hit[4:0];
            o.is_uptodate = slot_fresh[hit];
            touch_slot(hit);
            return;
         end
         for (int i = 0; i < Slots; i++) begin
            s = lru_list[i];
            if (slot_refs[s] == 0) begin
               if (slot_valid[s] && slot_dirty[s]) begin
                  o.writeback_valid = 1'b1;
                  o.writeback_device = slot_dev[s];
                  o.writeback_block = slot_block[s];
               end
               slot_dirty[s] = 1'b0;
               slot_valid[s] = 1'b1;
               slot_block[s] = r.block_number;
               slot_dev[s] = r.device_id;
               slot_size[s] = r.block_size_log2;
               slot_refs[s] = 16'd1;
               slot_fresh[s] = 1'b0;
               o.status = ST_MISS;
               o.granted_slot = s[4:0];
               touch_slot(s);
               return;
            end
         end
         o.status = ST_FULL;
         return;
      end
      o.status = ST_DONE;
      s = int'(r.target_slot);
      case (r.req_type)
         REQ_RELEASE: begin
            if (slot_valid[s] && slot_dirty[s]) begin
               o.writeback_valid = 1'b1;
               o.writeback_device = slot_dev[s];
               o.writeback_block = slot_block[s];
               slot_dirty[s] = 1'b0;
            end
            if (slot_refs[s] != 0) slot_refs[s]--;
         end
         REQ_DIRTY: if (slot_valid[s]) slot_dirty[s] = 1'b1;
         REQ_RD_DONE: if (slot_valid[s]) slot_fresh[s] = 1'b1;
         REQ_RD_FAIL: begin
            slot_valid[s] = 1'b0;
            slot_refs[s] = '0;
            slot_dirty[s] = 1'b0;
            slot_fresh[s] = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Send one request beat; start stays high until the beat is taken, then
   // drops while the core is busy anyway.
   task automatic send_beat(input req_type_type r);
      rsp_type o;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1'b1;
      req_beat <= r;
      do @(posedge clock); while (busy);
      predict_cache(r, o);
      pending_rsp.push_back(o);
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type_type make_req(input logic [2:0] kind, input logic [3:0] dev,
                                            input logic [31:0] blk, input logic [4:0] sz,
                                            input logic [4:0] slot);
      req_type_type r;
      r.req_type = kind;
      r.device_id = dev;
      r.block_number = blk;
      r.block_size_log2 = sz;
      r.target_slot = slot;
      return r;
   endfunction

   // Response checker: the receiver cannot stall, so every strobe is a beat.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response beat");
            error_count++;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_beat.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_beat.status);
               error_count++;
            end
            if (rsp_beat.granted_slot !== e.granted_slot) begin
               $error("granted_slot exp %0d got %0d", e.granted_slot,
                      rsp_beat.granted_slot);
               error_count++;
            end
            if (rsp_beat.is_uptodate !== e.is_uptodate) begin
               $error("is_uptodate exp %0d got %0d", e.is_uptodate,
                      rsp_beat.is_uptodate);
               error_count++;
            end
            if (rsp_beat.writeback_valid !== e.writeback_valid) begin
               $error("writeback_valid exp %0d got %0d", e.writeback_valid,
                      rsp_beat.writeback_valid);
               error_count++;
            end
            if (rsp_beat.writeback_device !== e.writeback_device) begin
               $error("writeback_device exp %0d got %0d", e.writeback_device,
                      rsp_beat.writeback_device);
               error_count++;
            end
            if (rsp_beat.writeback_block !== e.writeback_block) begin
               $error("writeback_block exp %h got %h", e.writeback_block,
                      rsp_beat.writeback_block);
               error_count++;
            end
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Extremes, every request kind and the named corner cases.
   task automatic test_directed();
      send_beat(make_req(REQ_GET, 4'd0, 32'd0, 5'd9, 5'd0));          // miss into slot 31
      send_beat(make_req(REQ_GET, 4'd0, 32'd0, 5'd9, 5'd0));          // hit, two refs
      send_beat(make_req(REQ_GET, 4'd15, 32'hFFFFFFFF, 5'd16, 5'd0));
      send_beat(make_req(REQ_GET, 4'd0, 32'd0, 5'd31, 5'd0));         // size mismatch
      send_beat(make_req(REQ_RD_DONE, 4'd0, 32'd0, 5'd0, 5'd31));
      send_beat(make_req(REQ_GET, 4'd0, 32'd0, 5'd9, 5'd0));          // hit up to date
      send_beat(make_req(REQ_DIRTY, 4'd0, 32'd0, 5'd0, 5'd31));
      send_beat(make_req(REQ_RELEASE, 4'd0, 32'd0, 5'd0, 5'd31));     // write back
      send_beat(make_req(REQ_DIRTY, 4'd0, 32'd0, 5'd0, 5'd0));        // invalid slot
      send_beat(make_req(REQ_RD_DONE, 4'd0, 32'd0, 5'd0, 5'd0));
      send_beat(make_req(REQ_RELEASE, 4'd0, 32'd0, 5'd0, 5'd0));      // refs stay zero
      send_beat(make_req(REQ_RD_FAIL, 4'd0, 32'd0, 5'd0, 5'd30));
      send_beat(make_req(3'd5, 4'd0, 32'd0, 5'd0, 5'd1));
      send_beat(make_req(3'd7, 4'hF, 32'hFFFFFFFF, 5'h1F, 5'h1F));
      // fresh tag: miss, then hit on the slot it took
      send_beat(make_req(REQ_GET, 4'd3, 32'h1234, 5'd12, 5'd0));
      send_beat(make_req(REQ_GET, 4'd3, 32'h1234, 5'd12, 5'd0));
   endtask

   // Fill every slot with references until gets find no free slot, then dirty and release every slot.
   task automatic test_full_cache();
      for (int i = 0; i < Slots + 2; i++)
         send_beat(make_req(REQ_GET, 4'd7, 32'h8000_0000 + i, 5'd10, 5'd0));
      wait_drained();   // hold off until every response beat is checked
      for (int i = 0; i < Slots; i++) begin
         send_beat(make_req(REQ_DIRTY, 4'd0, 32'd0, 5'd0, i[4:0]));
         while (slot_refs[i] != 0)
            send_beat(make_req(REQ_RELEASE, 4'd0, 32'd0, 5'd0, i[4:0]));
      end
   endtask

   // Pile references on one slot, then release them all again.
   task automatic test_ref_hammer();
      for (int i = 0; i < 30; i++)
         send_beat(make_req(REQ_GET, 4'd1, 32'd5, 5'd9, 5'd0));
      while (slot_refs[lru_list[Slots - 1]] != 0)
         send_beat(make_req(REQ_RELEASE, 4'd0, 32'd0, 5'd0, 5'(lru_list[Slots - 1])));
   endtask

   // Mostly well-formed get / read / dirty / release flows over a small tag
   // pool so hits, evictions and write-backs all occur; some noise mixed in.
   task automatic test_random(input int count);
      req_type_type r;
      int k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         r = make_req(3'($urandom_range(7)), 4'($urandom), $urandom, 5'($urandom),
                      5'($urandom));
         if (k < 40) begin
            r.req_type = REQ_GET;
            if (k < 35) begin
               r.device_id = 4'($urandom_range(1));
               r.block_number = $urandom_range(40);
               r.block_size_log2 = 5'($urandom_range(10, 9));
            end
         end else if (k < 85) begin
            r.req_type = k < 60 ? REQ_RELEASE : k < 70 ? REQ_DIRTY :
                         k < 80 ? REQ_RD_DONE : REQ_RD_FAIL;
         end
         send_beat(r);
      end
   endtask

   initial begin
      for (int i = 0; i < Slots; i++) begin
         slot_valid[i] = 0; slot_block[i] = 0; slot_dev[i] = 0; slot_size[i] = 0;
         slot_refs[i] = 0; slot_dirty[i] = 0; slot_fresh[i] = 0;
         lru_list[i] = Slots - 1 - i;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_cache();
      test_ref_hammer();
      test_random(420);
      idle_pct = 57;
      test_random(420);
      idle_pct = 25;
      test_random(420);
      idle_pct = 0;
      test_random(420);

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
